[hdl/bsc_pkg.sv]
// shared types, constants and helpers for the barometric sensor compensation block
package bsc_pkg;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DT_W    = 25;
   localparam int MUL_W   = 26;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int EXT_W   = 42;
   localparam int SQ_W    = 40;
   localparam int TEMP_W  = 19;
   localparam int TOUT_W  = 20;
   localparam int PRES_W  = 17;
   localparam int ACC_W   = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_SENSITIVITY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_OFFSET       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_COEF_SENSITIVITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_COEF_OFFSET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_TEMPERATURE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_COEF_TEMPERATURE = 3'd5;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -19'sd1500;
   localparam logic signed [ACC_W-1:0]  PRES_MIN  = 64'sd30000;
   localparam logic signed [ACC_W-1:0]  PRES_MAX  = 64'sd125000;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity;
      logic [CAL_W-1:0] pressure_offset;
      logic [CAL_W-1:0] temp_coef_sensitivity;
      logic [CAL_W-1:0] temp_coef_offset;
      logic [CAL_W-1:0] reference_temperature;
      logic [CAL_W-1:0] temp_coef_temperature;
   } cal_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DT,
      OP_MUL_C4,
      OP_MUL_C3,
      OP_MUL_C6,
      OP_MUL_Q,
      OP_MUL_SQ1,
      OP_MUL_SQ2,
      OP_CORR2,
      OP_MUL_PLO,
      OP_MUL_PHI,
      OP_ACC,
      OP_SCALE,
      OP_FINAL,
      OP_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DT,
      ST_MUL_C4,
      ST_MUL_C3,
      ST_MUL_C6,
      ST_MUL_Q,
      ST_MUL_SQ1,
      ST_MUL_SQ2,
      ST_CORR2,
      ST_MUL_PLO,
      ST_MUL_PHI,
      ST_ACC,
      ST_SCALE,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   // signed shift right that rounds toward zero
   function automatic logic signed [ACC_W-1:0] trunc_shift(
      input logic signed [ACC_W-1:0] x,
      input int unsigned             k
   );
      logic signed [ACC_W-1:0] bias;
      bias = x[ACC_W-1] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (x + bias) >>> k;
   endfunction

endpackage

[hdl/barometric_sensor_compensation.sv]
// top level of the barometric sensor compensation block
// One item (raw temperature and raw pressure) is taken while the block is idle, and the
// block takes no new item until it is through with that one. Each item makes eight passes
// through the one shared 26x26 signed multiplier plus the accumulate, scale and window
// steps. The result sits in an output register, so the next item is taken while it waits.
// Besides while an item is worked on, the input stalls only when a finished result still
// finds the output register full.
// Calibration words are written through the csr port, ready at all times, and must only be
// written while no item is in flight. Pressure is held at zero until the first in-window value.
module barometric_sensor_compensation import bsc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_W-1:0]         req_raw_temperature,
   input  logic [RAW_W-1:0]         req_raw_pressure,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TOUT_W-1:0] rsp_temperature_centi,
   output logic [PRES_W-1:0]        rsp_pressure,
   output logic                     rsp_pressure_accepted,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CAL_W-1:0]         csr_data
);

   cal_type    cal_ff, cal_in;
   dp_cmd_type cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   always_comb begin
      cal_in = cal_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRESSURE_SENSITIVITY:  cal_in.pressure_sensitivity  = csr_data;
            CSR_PRESSURE_OFFSET:       cal_in.pressure_offset       = csr_data;
            CSR_TEMP_COEF_SENSITIVITY: cal_in.temp_coef_sensitivity = csr_data;
            CSR_TEMP_COEF_OFFSET:      cal_in.temp_coef_offset      = csr_data;
            CSR_REFERENCE_TEMPERATURE: cal_in.reference_temperature = csr_data;
            CSR_TEMP_COEF_TEMPERATURE: cal_in.temp_coef_temperature = csr_data;
            default:                   cal_in = cal_ff;
         endcase
      end
   end

   bsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bsc_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .cal                   (cal_ff),
      .req_raw_temperature   (req_raw_temperature),
      .req_raw_pressure      (req_raw_pressure),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure          (rsp_pressure),
      .rsp_pressure_accepted (rsp_pressure_accepted)
   );

   // an accepted item keeps the input side stalled while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after item accepted");

   // a stored pressure lies strictly inside the window
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pressure_accepted) |->
         (rsp_pressure > 17'd30000) && (rsp_pressure < 17'd125000))
      else $error("accepted pressure outside window");

   // a rejected pressure leaves the held value untouched
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !rsp_pressure_accepted) |-> $stable(rsp_pressure))
      else $error("held pressure changed on rejected item");

endmodule

[hdl/bsc_ctrl.sv]
// sequencer that steps the shared multiplier datapath through one item
module bsc_ctrl import bsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DT;
            end
         end
         ST_DT: begin
            cmd.op   = OP_DT;
            state_in = ST_MUL_C4;
         end
         ST_MUL_C4: begin
            cmd.op   = OP_MUL_C4;
            state_in = ST_MUL_C3;
         end
         ST_MUL_C3: begin
            cmd.op   = OP_MUL_C3;
            state_in = ST_MUL_C6;
         end
         ST_MUL_C6: begin
            cmd.op   = OP_MUL_C6;
            state_in = ST_MUL_Q;
         end
         ST_MUL_Q: begin
            cmd.op   = OP_MUL_Q;
            state_in = ST_MUL_SQ1;
         end
         ST_MUL_SQ1: begin
            cmd.op   = OP_MUL_SQ1;
            state_in = ST_MUL_SQ2;
         end
         ST_MUL_SQ2: begin
            cmd.op   = OP_MUL_SQ2;
            state_in = ST_CORR2;
         end
         ST_CORR2: begin
            cmd.op   = OP_CORR2;
            state_in = ST_MUL_PLO;
         end
         ST_MUL_PLO: begin
            cmd.op   = OP_MUL_PLO;
            state_in = ST_MUL_PHI;
         end
         ST_MUL_PHI: begin
            cmd.op   = OP_MUL_PHI;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.op   = OP_FINAL;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/bsc_datapath.sv]
// compensation datapath around one shared 26x26 signed multiplier
module bsc_datapath import bsc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  cal_type                  cal,
   input  logic [RAW_W-1:0]         req_raw_temperature,
   input  logic [RAW_W-1:0]         req_raw_pressure,
   output logic signed [TOUT_W-1:0] rsp_temperature_centi,
   output logic [PRES_W-1:0]        rsp_pressure,
   output logic                     rsp_pressure_accepted
);

   logic [RAW_W-1:0]         d1_ff, d1_in;
   logic [RAW_W-1:0]         d2_ff, d2_in;
   logic signed [DT_W-1:0]   dt_ff, dt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [EXT_W-1:0]  off_ff, off_in;
   logic signed [EXT_W-1:0]  sens_ff, sens_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic signed [TOUT_W-1:0] tout_ff, tout_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [TOUT_W-1:0] out_temp_ff, out_temp_in;
   logic [PRES_W-1:0]        held_ff, held_in;
   logic                     out_ok_ff, out_ok_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [SQ_W-1:0]   sq, sq5, sq7, sq11;
   logic signed [TOUT_W:0]   tout_wide;
   logic                     in_window;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      dt_ff       <= dt_in;
      prod_ff     <= prod_in;
      off_ff      <= off_in;
      sens_ff     <= sens_in;
      temp_ff     <= temp_in;
      tout_ff     <= tout_in;
      acc_ff      <= acc_in;
      out_temp_ff <= out_temp_in;
      out_ok_ff   <= out_ok_in;
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_C4: begin
            mul_a = $signed({{(MUL_W-CAL_W){1'b0}}, cal.temp_coef_offset});
            mul_b = MUL_W'(dt_ff);
         end
         OP_MUL_C3: begin
            mul_a = $signed({{(MUL_W-CAL_W){1'b0}}, cal.temp_coef_sensitivity});
            mul_b = MUL_W'(dt_ff);
         end
         OP_MUL_C6: begin
            mul_a = $signed({{(MUL_W-CAL_W){1'b0}}, cal.temp_coef_temperature});
            mul_b = MUL_W'(dt_ff);
         end
         OP_MUL_Q: begin
            mul_a = MUL_W'(trunc_shift(ACC_W'(dt_ff), 15));
            mul_b = MUL_W'(dt_ff);
         end
         OP_MUL_SQ1: begin
            mul_a = MUL_W'(temp_ff) - MUL_W'(TEMP_BASE);
            mul_b = MUL_W'(temp_ff) - MUL_W'(TEMP_BASE);
         end
         OP_MUL_SQ2: begin
            mul_a = MUL_W'(temp_ff) - MUL_W'(TEMP_LOW);
            mul_b = MUL_W'(temp_ff) - MUL_W'(TEMP_LOW);
         end
         OP_MUL_PLO: begin
            mul_a = $signed({{(MUL_W-RAW_W){1'b0}}, d1_ff});
            mul_b = $signed({{(MUL_W-24){1'b0}}, sens_ff[23:0]});
         end
         OP_MUL_PHI: begin
            mul_a = $signed({{(MUL_W-RAW_W){1'b0}}, d1_ff});
            mul_b = MUL_W'($signed(sens_ff[EXT_W-1:24]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_ext  = ACC_W'(prod_ff);
   assign sq        = SQ_W'(prod_ff);
   assign sq5       = (sq <<< 2) + sq;
   assign sq7       = (sq <<< 3) - sq;
   assign sq11      = (sq <<< 3) + (sq <<< 1) + sq;
   assign tout_wide = (TOUT_W+1)'(temp_ff) - (TOUT_W+1)'(trunc_shift(prod_ext, 16));
   assign in_window = (acc_ff > PRES_MIN) && (acc_ff < PRES_MAX);

   always_comb begin
      d1_in       = d1_ff;
      d2_in       = d2_ff;
      dt_in       = dt_ff;
      prod_in     = mul_a * mul_b;
      off_in      = off_ff;
      sens_in     = sens_ff;
      temp_in     = temp_ff;
      tout_in     = tout_ff;
      acc_in      = acc_ff;
      out_temp_in = out_temp_ff;
      out_ok_in   = out_ok_ff;
      held_in     = held_ff;
      case (cmd.op)
         OP_LOAD: begin
            d1_in = req_raw_pressure;
            d2_in = req_raw_temperature;
         end
         OP_DT: begin
            dt_in = $signed({1'b0, d2_ff}) - $signed({1'b0, cal.reference_temperature, 8'h00});
         end
         OP_MUL_C3: begin
            off_in = EXT_W'($signed({1'b0, cal.pressure_offset, 16'h0000}))
                   + EXT_W'(trunc_shift(prod_ext, 7));
         end
         OP_MUL_C6: begin
            sens_in = EXT_W'($signed({1'b0, cal.pressure_sensitivity, 15'h0000}))
                    + EXT_W'(trunc_shift(prod_ext, 8));
         end
         OP_MUL_Q: begin
            temp_in = TEMP_W'(ACC_W'(TEMP_BASE) + trunc_shift(prod_ext, 23));
         end
         OP_MUL_SQ1: begin
            tout_in = TOUT_W'(tout_wide);
         end
         OP_MUL_SQ2: begin
            // first correction below 20.00 C
            if (temp_ff < TEMP_BASE) begin
               off_in  = off_ff - EXT_W'(sq5 >>> 1);
               sens_in = sens_ff - EXT_W'(sq5 >>> 2);
            end
         end
         OP_CORR2: begin
            // second correction below -15.00 C
            if (temp_ff < TEMP_LOW) begin
               off_in  = off_ff - EXT_W'(sq7);
               sens_in = sens_ff - EXT_W'(sq11 >>> 1);
            end
         end
         OP_MUL_PHI: begin
            acc_in = prod_ext;
         end
         OP_ACC: begin
            acc_in = acc_ff + (prod_ext <<< 24);
         end
         OP_SCALE: begin
            acc_in = trunc_shift(acc_ff, 21) - ACC_W'(off_ff);
         end
         OP_FINAL: begin
            acc_in = trunc_shift(acc_ff, 15);
         end
         OP_OUT: begin
            out_temp_in = tout_ff;
            out_ok_in   = in_window;
            if (in_window) begin
               held_in = acc_ff[PRES_W-1:0];
            end
         end
         default: begin
            d1_in = d1_ff;
         end
      endcase
   end

   assign rsp_temperature_centi = out_temp_ff;
   assign rsp_pressure          = held_ff;
   assign rsp_pressure_accepted = out_ok_ff;

endmodule
